>>> hw/rtl/linear_probe_hash_table_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the linear probe hash table core
// Immediate-implication and next-cycle-implication checks with async reset.
// ----------------------------------------------------------------------------
`ifndef LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH
`define LINEAR_PROBE_HASH_TABLE_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LPHT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash table check failed");

// The consequent must hold in the cycle after the antecedent.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash table check failed");

`endif

>>> hw/rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// Linear probe hash table package
// Sizes, operation and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lpht_pkg;

  // Table depth must be a power of two: the home slot is the key's low bits.
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;

  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned KEY_W    = 64;
  localparam int unsigned PLY_W    = 16;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned SLOT_W   = 10;
  localparam int unsigned COUNT_W  = 11;
  localparam int unsigned LIMIT_W  = 11;

  localparam int unsigned CMP_W = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;

  // Default fill limit is nine tenths of the table.
  localparam logic [LIMIT_W-1:0] FILL_LIMIT_RESET = LIMIT_W'((TABLE_DEPTH * 9) / 10);

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOOKUP_INSERT = 2'd0,
    OP_LOOKUP_ONLY   = 2'd1,
    OP_CLEAR         = 2'd2
  } opcode_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_FOUND    = 3'd0,
    STATUS_INSERTED = 3'd1,
    STATUS_ABSENT   = 3'd2,
    STATUS_FULL     = 3'd3,
    STATUS_CLEARED  = 3'd4
  } status_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    accept;          // latch the incoming request
    logic    start_clear;     // zero the count, set the flag, restart sweep
    logic    wipe;            // write an empty entry and step the address
    logic    advance;         // step to the next probe slot
    logic    insert;          // claim the current slot
    logic    set_result;      // capture a result code
    status_e result;
    logic    result_at_slot;  // result slot is the current address, else zero
    logic    load_out;        // move the result into the output register
  } lpht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic entry_valid;
    logic entry_hit;
    logic wrap;
    logic sweep_last;
  } lpht_sts_t;

endpackage

>>> hw/rtl/lpht_stream_if.sv
// ----------------------------------------------------------------------------
// Linear probe hash table stream interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lpht_req_if;
  import lpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [KEY_W-1:0]    search_key;
  logic [PLY_W-1:0]    ply_tag;

  modport source (output valid, opcode, search_key, ply_tag, input ready);
  modport sink   (input valid, opcode, search_key, ply_tag, output ready);
endinterface

interface lpht_rsp_if;
  import lpht_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [SLOT_W-1:0]   slot_index;
  logic                capacity_ok;
  logic [COUNT_W-1:0]  used_count;

  modport source (output valid, status, slot_index, capacity_ok, used_count, input ready);
  modport sink   (input valid, status, slot_index, capacity_ok, used_count, output ready);
endinterface

>>> hw/rtl/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// Linear probe hash table controller
// Sequences sweeps, probes and result hand-off for one request at a time.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_ctrl (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  input  logic [lpht_pkg::OPCODE_W-1:0] req_opcode_i,
  output logic                          req_ready_o,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output lpht_pkg::lpht_cmd_t           cmd_o,
  input  lpht_pkg::lpht_sts_t           sts_i
);
  import lpht_pkg::*;

  typedef enum logic [5:0] {
    ST_INIT  = 6'b000001,
    ST_IDLE  = 6'b000010,
    ST_WIPE  = 6'b000100,
    ST_READ  = 6'b001000,
    ST_CHECK = 6'b010000,
    ST_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic   rsp_valid_q, rsp_valid_d;
  logic   lookup_only_q, lookup_only_d;

  always_comb begin
    cmd_o         = '0;
    cmd_o.result  = STATUS_ABSENT;
    state_d       = state_q;
    lookup_only_d = lookup_only_q;
    req_ready_o   = 1'b0;

    case (state_q)
      ST_INIT: begin
        // Sweep after reset leaves every slot empty.
        cmd_o.wipe = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.accept  = 1'b1;
          lookup_only_d = (req_opcode_i == OP_LOOKUP_ONLY);
          case (req_opcode_i)
            OP_LOOKUP_INSERT, OP_LOOKUP_ONLY: begin
              state_d = ST_READ;
            end
            OP_CLEAR: begin
              cmd_o.start_clear = 1'b1;
              cmd_o.set_result  = 1'b1;
              cmd_o.result      = STATUS_CLEARED;
              state_d           = ST_WIPE;
            end
            default: begin
              // Undefined operation: report absent and touch nothing.
              cmd_o.set_result = 1'b1;
              cmd_o.result     = STATUS_ABSENT;
              state_d          = ST_DONE;
            end
          endcase
        end
      end
      ST_WIPE: begin
        cmd_o.wipe = 1'b1;
        if (sts_i.sweep_last) begin
          state_d = ST_DONE;
        end
      end
      ST_READ: begin
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        if (sts_i.entry_valid) begin
          if (sts_i.entry_hit) begin
            cmd_o.set_result     = 1'b1;
            cmd_o.result         = STATUS_FOUND;
            cmd_o.result_at_slot = 1'b1;
            state_d              = ST_DONE;
          end else if (sts_i.wrap) begin
            cmd_o.set_result = 1'b1;
            cmd_o.result     = lookup_only_q ? STATUS_ABSENT : STATUS_FULL;
            state_d          = ST_DONE;
          end else begin
            cmd_o.advance = 1'b1;
            state_d       = ST_READ;
          end
        end else if (lookup_only_q) begin
          cmd_o.set_result = 1'b1;
          cmd_o.result     = STATUS_ABSENT;
          state_d          = ST_DONE;
        end else begin
          cmd_o.insert         = 1'b1;
          cmd_o.set_result     = 1'b1;
          cmd_o.result         = STATUS_INSERTED;
          cmd_o.result_at_slot = 1'b1;
          state_d              = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!rsp_valid_q || rsp_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd_o.load_out) begin
      rsp_valid_d = 1'b1;
    end else if (rsp_ready_i) begin
      rsp_valid_d = 1'b0;
    end else begin
      rsp_valid_d = rsp_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_INIT;
      rsp_valid_q   <= 1'b0;
      lookup_only_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      rsp_valid_q   <= rsp_valid_d;
      lookup_only_q <= lookup_only_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;

endmodule

>>> hw/rtl/lpht_datapath.sv
// ----------------------------------------------------------------------------
// Linear probe hash table datapath
// Slot memory, probe address, fill count, capacity flag and result registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lpht_datapath (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [lpht_pkg::KEY_W-1:0]    search_key_i,
  input  logic [lpht_pkg::PLY_W-1:0]    ply_tag_i,
  input  logic                          cfg_we_i,
  input  logic [lpht_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  lpht_pkg::lpht_cmd_t           cmd_i,
  output lpht_pkg::lpht_sts_t           sts_o,
  output logic [lpht_pkg::STATUS_W-1:0] status_o,
  output logic [lpht_pkg::SLOT_W-1:0]   slot_index_o,
  output logic                          capacity_ok_o,
  output logic [lpht_pkg::COUNT_W-1:0]  used_count_o
);
  import lpht_pkg::*;

  typedef struct packed {
    logic             valid;
    logic [KEY_W-1:0] key;
    logic [PLY_W-1:0] ply;
  } entry_t;

  entry_t table_mem [TABLE_DEPTH];
  entry_t rd_q;

  logic [ADDR_W-1:0]  addr_q, addr_d, addr_next;
  logic [CNT_W-1:0]   count_q, count_d, count_inc;
  logic               flag_q, flag_d;
  logic [LIMIT_W-1:0] limit_q, limit_d;

  logic [ADDR_W-1:0]  home_q;
  logic [KEY_W-1:0]   key_q;
  logic [PLY_W-1:0]   ply_q;
  status_e            res_status_q;
  logic [ADDR_W-1:0]  res_slot_q;

  assign addr_next = addr_q + ADDR_W'(1);
  assign count_inc = count_q + CNT_W'(1);

  always_comb begin
    addr_d = addr_q;
    if (cmd_i.accept) begin
      addr_d = cmd_i.start_clear ? '0 : search_key_i[ADDR_W-1:0];
    end else if (cmd_i.wipe || cmd_i.advance) begin
      addr_d = addr_next;
    end
  end

  always_comb begin
    count_d = count_q;
    flag_d  = flag_q;
    if (cmd_i.start_clear) begin
      count_d = '0;
      flag_d  = 1'b1;
    end else if (cmd_i.insert) begin
      count_d = count_inc;
      // Once cleared, the flag only comes back with a table clear or a reset.
      if (CMP_W'(count_inc) > CMP_W'(limit_q)) begin
        flag_d = 1'b0;
      end
    end
  end

  assign limit_d = cfg_we_i ? cfg_wdata_i : limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      count_q <= '0;
      flag_q  <= 1'b1;
      limit_q <= FILL_LIMIT_RESET;
    end else begin
      addr_q  <= addr_d;
      count_q <= count_d;
      flag_q  <= flag_d;
      limit_q <= limit_d;
    end
  end

  // Single write port and one registered read port, both at the probe address.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wipe) begin
      table_mem[addr_q] <= '0;
    end else if (cmd_i.insert) begin
      table_mem[addr_q] <= '{valid: 1'b1, key: key_q, ply: ply_q};
    end
    rd_q <= table_mem[addr_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      home_q <= search_key_i[ADDR_W-1:0];
      key_q  <= search_key_i;
      ply_q  <= ply_tag_i;
    end
    if (cmd_i.set_result) begin
      res_status_q <= cmd_i.result;
      res_slot_q   <= cmd_i.result_at_slot ? addr_q : '0;
    end
    if (cmd_i.load_out) begin
      status_o      <= res_status_q;
      slot_index_o  <= SLOT_W'(res_slot_q);
      capacity_ok_o <= flag_q;
      used_count_o  <= COUNT_W'(count_q);
    end
  end

  assign sts_o.entry_valid = rd_q.valid;
  assign sts_o.entry_hit   = rd_q.valid && (rd_q.key == key_q) && (rd_q.ply == ply_q);
  assign sts_o.wrap        = (addr_next == home_q);
  assign sts_o.sweep_last  = &addr_q;

endmodule

>>> hw/rtl/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// Linear probe hash table core
// An open-addressing table of 1024 slots keyed by a 64-bit position key and a
// 16-bit ply. Opcode 0 looks up the key and inserts it into the first empty
// slot if it is missing, opcode 1 only looks it up, and opcode 2 empties the
// table. Probing starts at the key's low ten bits and walks one slot at a
// time, wrapping at the end of the table. Each probed slot takes a read state
// and a check state because the single slot memory has a registered read
// port, and every result passes a done state on its way to the output
// register. A table clear writes one empty slot per cycle, and after reset
// the same sweep runs over every slot before the first request transfer is
// taken. An undefined opcode answers absent without a probe. The result sits
// in an output register, so the next request is accepted while a finished
// response waits for its transfer; a second finished result then waits
// until that transfer happens. The capacity flag drops when an insert pushes
// the used count above the fill limit and comes back only with a table clear
// or a reset; a new fill limit is compared at the next insert. The fill limit
// may be written only while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "linear_probe_hash_table_core_assert.svh"

module linear_probe_hash_table_core (
  input logic                         clk_i,
  input logic                         rst_ni,
  lpht_req_if.sink                    req_i,
  lpht_rsp_if.source                  rsp_o,
  input logic                         cfg_we_i,
  input logic [lpht_pkg::LIMIT_W-1:0] cfg_wdata_i
);
  import lpht_pkg::*;

  // Command and status bundles between the controller and the datapath.
  lpht_cmd_t cmd;
  lpht_sts_t sts;

  // Response views used by the checks at the end of the module.
  logic rsp_is_clear;
  logic rsp_fill_empty;
  logic rsp_no_slot;
  logic rsp_count_in_range;

  // The controller owns the handshakes and decides every step of a request.
  lpht_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (req_i.valid),
    .req_opcode_i (req_i.opcode),
    .req_ready_o  (req_i.ready),
    .rsp_valid_o  (rsp_o.valid),
    .rsp_ready_i  (rsp_o.ready),
    .cmd_o        (cmd),
    .sts_i        (sts)
  );

  // The datapath holds the slots, the counters and the response payload.
  lpht_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .search_key_i  (req_i.search_key),
    .ply_tag_i     (req_i.ply_tag),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (rsp_o.status),
    .slot_index_o  (rsp_o.slot_index),
    .capacity_ok_o (rsp_o.capacity_ok),
    .used_count_o  (rsp_o.used_count)
  );

  assign rsp_is_clear       = rsp_o.valid && (rsp_o.status == STATUS_CLEARED);
  assign rsp_fill_empty     = rsp_o.capacity_ok && (rsp_o.used_count == '0);
  assign rsp_no_slot        = rsp_o.valid && (rsp_o.status == STATUS_ABSENT ||
                                              rsp_o.status == STATUS_FULL ||
                                              rsp_o.status == STATUS_CLEARED);
  assign rsp_count_in_range = (rsp_o.used_count <= COUNT_W'(TABLE_DEPTH));

  // A request transfer always takes the block out of its ready state.
  `LPHT_ASSERT_NEXT(a_busy_after_req, clk_i, rst_ni, req_i.valid && req_i.ready, !req_i.ready)

  // A clear answer shows an empty table with the capacity flag set.
  `LPHT_ASSERT_NOW(a_clear_resets_fill, clk_i, rst_ni, rsp_is_clear, rsp_fill_empty)

  // Only found and inserted answers carry a slot number.
  `LPHT_ASSERT_NOW(a_slot_zero, clk_i, rst_ni, rsp_no_slot, rsp_o.slot_index == '0)

  // The used count never passes the table size.
  `LPHT_ASSERT_NOW(a_count_bound, clk_i, rst_ni, rsp_o.valid, rsp_count_in_range)

endmodule
